/* design/gbcs_pkg.sv */
// Shared types and constants for the group box collision scan block.
`default_nettype none
package gbcs_pkg;

   localparam int SLOT_BITS  = 5;
   localparam int GROUP_BITS = 5;
   localparam int SIZE_BITS  = 16;

   typedef enum logic [1:0] {
      KIND_WRITE       = 2'd0,
      KIND_CLEAR       = 2'd1,
      KIND_GROUP_CLEAR = 2'd2,
      KIND_SCAN        = 2'd3
   } kind_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic                  shift;
      logic                  write;
      logic                  clear;
      logic                  group_clear;
      logic [GROUP_BITS-1:0] clear_group;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* design/gbcs_cell.sv */
// One slot cell of the rotating slot ring: valid mark, group tag and box.
`default_nettype none
module gbcs_cell #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire gbcs_pkg::cell_ctrl_type                 ctrl,
   // broadcast write data
   input  wire logic [gbcs_pkg::GROUP_BITS-1:0]         wr_group,
   input  wire logic signed [COORD_BITS-1:0]            wr_left,
   input  wire logic signed [COORD_BITS-1:0]            wr_top,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]          wr_width,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]          wr_height,
   // neighbor cell contents
   input  wire logic                                    nb_valid,
   input  wire logic [gbcs_pkg::GROUP_BITS-1:0]         nb_group,
   input  wire logic signed [COORD_BITS-1:0]            nb_left,
   input  wire logic signed [COORD_BITS-1:0]            nb_top,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]          nb_width,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]          nb_height,
   // own contents
   output logic                                         cell_valid,
   output logic [gbcs_pkg::GROUP_BITS-1:0]              cell_group,
   output logic signed [COORD_BITS-1:0]                 cell_left,
   output logic signed [COORD_BITS-1:0]                 cell_top,
   output logic [gbcs_pkg::SIZE_BITS-1:0]               cell_width,
   output logic [gbcs_pkg::SIZE_BITS-1:0]               cell_height
);
   import gbcs_pkg::*;

   logic                         valid_ff, valid_in;
   logic [GROUP_BITS-1:0]        group_ff, group_in;
   logic signed [COORD_BITS-1:0] left_ff, left_in;
   logic signed [COORD_BITS-1:0] top_ff, top_in;
   logic [SIZE_BITS-1:0]         width_ff, width_in;
   logic [SIZE_BITS-1:0]         height_ff, height_in;

   // Next contents: rotate, write, clear or group clear
   always_comb begin
      valid_in  = valid_ff;
      group_in  = group_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (ctrl.shift) begin
         valid_in  = nb_valid;
         group_in  = nb_group;
         left_in   = nb_left;
         top_in    = nb_top;
         width_in  = nb_width;
         height_in = nb_height;
      end else if (ctrl.write) begin
         valid_in  = 1'b1;
         group_in  = wr_group;
         left_in   = wr_left;
         top_in    = wr_top;
         width_in  = wr_width;
         height_in = wr_height;
      end else if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.group_clear && valid_ff && (group_ff == ctrl.clear_group)) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff  <= group_in;
      left_ff   <= left_in;
      top_ff    <= top_in;
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   assign cell_valid  = valid_ff;
   assign cell_group  = group_ff;
   assign cell_left   = left_ff;
   assign cell_top    = top_ff;
   assign cell_width  = width_ff;
   assign cell_height = height_ff;

endmodule
`default_nettype wire

/* design/gbcs_overlap.sv */
// Box overlap comparator between the probe box and the box at the ring head.
`default_nettype none
module gbcs_overlap #(
   parameter int COORD_BITS = 16
) (
   input  wire logic signed [COORD_BITS-1:0]           a_left,
   input  wire logic signed [COORD_BITS-1:0]           a_top,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]         a_width,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]         a_height,
   input  wire logic signed [COORD_BITS-1:0]           b_left,
   input  wire logic signed [COORD_BITS-1:0]           b_top,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]         b_width,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]         b_height,
   output logic                                        overlap
);
   import gbcs_pkg::*;

   // wide enough that differences and sizes never wrap
   localparam int EW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

   logic signed [EW-1:0] dx_ab, dx_ba, dy_ab, dy_ba;
   logic [EW-1:0]        aw_ext, ah_ext, bw_ext, bh_ext;
   logic                 a_in_bx, b_in_ax, a_in_by, b_in_ay;

   // start a lies in [b, b + size_b) when 0 <= a - b < size_b
   always_comb begin
      dx_ab  = EW'(a_left) - EW'(b_left);
      dx_ba  = EW'(b_left) - EW'(a_left);
      dy_ab  = EW'(a_top) - EW'(b_top);
      dy_ba  = EW'(b_top) - EW'(a_top);
      aw_ext = EW'(a_width);
      ah_ext = EW'(a_height);
      bw_ext = EW'(b_width);
      bh_ext = EW'(b_height);

      a_in_bx = !dx_ab[EW-1] && ($unsigned(dx_ab) < bw_ext);
      b_in_ax = !dx_ba[EW-1] && ($unsigned(dx_ba) < aw_ext);
      a_in_by = !dy_ab[EW-1] && ($unsigned(dy_ab) < bh_ext);
      b_in_ay = !dy_ba[EW-1] && ($unsigned(dy_ba) < ah_ext);

      overlap = (a_in_bx || b_in_ax) && (a_in_by || b_in_ay);
   end

endmodule
`default_nettype wire

/* design/group_box_collision_scan.sv */
// Top level: slot ring of cells, scan sequencer and result register.
// Write, clear and group clear are each done on acceptance; group clear compares all cells at once.
// A scan of a valid slot is accepted, then rotates the ring once past one overlap
// comparator, then sends the final result; the ring holds while an earlier hit cannot be
// handed on, and the final result waits while the result channel stalls.
// A scan of an invalid or out-of-range slot goes straight to the flush state and sends one no-hit result.
// Synchronous reset clears every slot's valid mark; box contents are kept.
`default_nettype none
module group_box_collision_scan #(
   parameter int SLOTS      = 32,
   parameter int COORD_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [1:0]                              req_kind,
   input  wire logic [gbcs_pkg::SLOT_BITS-1:0]          req_slot,
   input  wire logic [gbcs_pkg::GROUP_BITS-1:0]         req_group_tag,
   input  wire logic signed [COORD_BITS-1:0]            req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]            req_pos_y,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]          req_box_w,
   input  wire logic [gbcs_pkg::SIZE_BITS-1:0]          req_box_h,
   // response channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_hit,
   output logic [gbcs_pkg::SLOT_BITS-1:0]               rsp_first_slot,
   output logic [gbcs_pkg::SLOT_BITS-1:0]               rsp_other_slot,
   output logic                                         rsp_last
);
   import gbcs_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = ((IW > SLOT_BITS) ? IW : SLOT_BITS) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // cell ring
   cell_ctrl_type                cell_ctrl   [SLOTS];
   logic                         cell_valid  [SLOTS];
   logic [GROUP_BITS-1:0]        cell_group  [SLOTS];
   logic signed [COORD_BITS-1:0] cell_left   [SLOTS];
   logic signed [COORD_BITS-1:0] cell_top    [SLOTS];
   logic [SIZE_BITS-1:0]         cell_width  [SLOTS];
   logic [SIZE_BITS-1:0]         cell_height [SLOTS];

   // sequencer state
   state_type                    state_ff, state_in;
   logic [IW-1:0]                cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0]         scan_slot_ff, scan_slot_in;
   logic [GROUP_BITS-1:0]        probe_group_ff, probe_group_in;
   logic signed [COORD_BITS-1:0] probe_left_ff, probe_left_in;
   logic signed [COORD_BITS-1:0] probe_top_ff, probe_top_in;
   logic [SIZE_BITS-1:0]         probe_width_ff, probe_width_in;
   logic [SIZE_BITS-1:0]         probe_height_ff, probe_height_in;
   logic                         pend_ff, pend_in;
   logic [SLOT_BITS-1:0]         pend_slot_ff, pend_slot_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [SLOT_BITS-1:0]         rsp_first_ff, rsp_first_in;
   logic [SLOT_BITS-1:0]         rsp_other_ff, rsp_other_in;
   logic                         rsp_last_ff, rsp_last_in;

   // decode and compare signals
   logic                         accept;
   logic [CW-1:0]                slot_ext;
   logic [CW-1:0]                cnt_ext;
   logic                         slot_ok;
   logic [IW-1:0]                sel_idx;
   logic                         wr_en, clr_en, grp_en, shift_en;
   logic                         head_overlap;
   logic                         match;
   logic                         out_free;

   // Slot ring; each cell takes the contents of the next one on a rotate
   for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
      localparam int NEXT = (gi + 1) % SLOTS;
      gbcs_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[gi]),
         .wr_group    (req_group_tag),
         .wr_left     (req_pos_x),
         .wr_top      (req_pos_y),
         .wr_width    (req_box_w),
         .wr_height   (req_box_h),
         .nb_valid    (cell_valid[NEXT]),
         .nb_group    (cell_group[NEXT]),
         .nb_left     (cell_left[NEXT]),
         .nb_top      (cell_top[NEXT]),
         .nb_width    (cell_width[NEXT]),
         .nb_height   (cell_height[NEXT]),
         .cell_valid  (cell_valid[gi]),
         .cell_group  (cell_group[gi]),
         .cell_left   (cell_left[gi]),
         .cell_top    (cell_top[gi]),
         .cell_width  (cell_width[gi]),
         .cell_height (cell_height[gi])
      );
   end

   // Comparator at the ring head (cell 0 holds slot cnt_ff during a scan)
   gbcs_overlap #(
      .COORD_BITS (COORD_BITS)
   ) u_overlap (
      .a_left   (probe_left_ff),
      .a_top    (probe_top_ff),
      .a_width  (probe_width_ff),
      .a_height (probe_height_ff),
      .b_left   (cell_left[0]),
      .b_top    (cell_top[0]),
      .b_width  (cell_width[0]),
      .b_height (cell_height[0]),
      .overlap  (head_overlap)
   );

   // Request decode
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_ext  = CW'(req_slot);
   assign slot_ok   = (slot_ext < CW'(SLOTS));
   assign sel_idx   = slot_ext[IW-1:0];
   assign cnt_ext   = CW'(cnt_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign match = (cnt_ext > CW'(scan_slot_ff)) && cell_valid[0] &&
                  (cell_group[0] != probe_group_ff) && head_overlap;

   // Sequencer next state and result register load
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      scan_slot_in    = scan_slot_ff;
      probe_group_in  = probe_group_ff;
      probe_left_in   = probe_left_ff;
      probe_top_in    = probe_top_ff;
      probe_width_in  = probe_width_ff;
      probe_height_in = probe_height_ff;
      pend_in         = pend_ff;
      pend_slot_in    = pend_slot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_other_in    = rsp_other_ff;
      rsp_last_in     = rsp_last_ff;
      wr_en           = 1'b0;
      clr_en          = 1'b0;
      grp_en          = 1'b0;
      shift_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_WRITE:       wr_en  = slot_ok;
                  KIND_CLEAR:       clr_en = slot_ok;
                  KIND_GROUP_CLEAR: grp_en = slot_ok && cell_valid[sel_idx];
                  KIND_SCAN: begin
                     scan_slot_in = req_slot;
                     pend_in      = 1'b0;
                     cnt_in       = '0;
                     if (slot_ok && cell_valid[sel_idx]) begin
                        probe_group_in  = cell_group[sel_idx];
                        probe_left_in   = cell_left[sel_idx];
                        probe_top_in    = cell_top[sel_idx];
                        probe_width_in  = cell_width[sel_idx];
                        probe_height_in = cell_height[sel_idx];
                        state_in        = ST_SCAN;
                     end else begin
                        state_in = ST_FLUSH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // hold the ring while an earlier hit cannot be handed on
            if (!(match && pend_ff && !out_free)) begin
               shift_en = 1'b1;
               if (match) begin
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b1;
                     rsp_first_in = scan_slot_ff;
                     rsp_other_in = pend_slot_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = cnt_ext[SLOT_BITS-1:0];
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ext == CW'(SLOTS - 1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            // final result: the held hit, or a no-hit
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = pend_ff;
               rsp_first_in = scan_slot_ff;
               rsp_other_in = pend_ff ? pend_slot_ff : '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Per-cell control
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         cell_ctrl[i].shift       = shift_en;
         cell_ctrl[i].write       = wr_en && (sel_idx == IW'(i));
         cell_ctrl[i].clear       = clr_en && (sel_idx == IW'(i));
         cell_ctrl[i].group_clear = grp_en;
         cell_ctrl[i].clear_group = cell_group[sel_idx];
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff          <= cnt_in;
      scan_slot_ff    <= scan_slot_in;
      probe_group_ff  <= probe_group_in;
      probe_left_ff   <= probe_left_in;
      probe_top_ff    <= probe_top_in;
      probe_width_ff  <= probe_width_in;
      probe_height_ff <= probe_height_in;
      pend_slot_ff    <= pend_slot_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_other_ff    <= rsp_other_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_first_slot = rsp_first_ff;
   assign rsp_other_slot = rsp_other_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire
